// ===== design/tcp_probe_reply_classifier_core_assert.svh =====
// assertion macros for the tcp probe reply classifier
`ifndef TCP_PROBE_REPLY_CLASSIFIER_CORE_ASSERT_SVH
`define TCP_PROBE_REPLY_CLASSIFIER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define TPRC_ASSERT_IMPLIES(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("tprc assertion failed");
`define TPRC_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("tprc assertion failed");
`else
`define TPRC_ASSERT_IMPLIES(label, clk, rst, cond, prop)
`define TPRC_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif

`endif

// ===== design/tprc_pkg.sv =====
// shared types and constants of the tcp probe reply classifier
package tprc_pkg;

   localparam int DEFAULT_TABLE_PORTS = 1024;
   localparam logic [10:0] PORT_COUNT_RESET = 11'd1024;

   localparam int BYTE_W   = 8;
   localparam int INDEX_W  = 10;
   localparam int PORT_W   = 16;
   localparam int COUNT_W  = 16;
   localparam int PCOUNT_W = 11;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [7:0] ETH_LEN   = 8'd14;
   localparam logic [3:0] MIN_WORDS = 4'd5;
   localparam logic [7:0] TCP_CAPTURE_LEN = 8'd14;
   localparam logic [7:0] FLAG_SYN  = 8'h02;
   localparam logic [7:0] FLAG_RST  = 8'h04;
   localparam logic [7:0] FLAG_ACK  = 8'h10;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic {
      CMD_BYTE = 1'b0,
      CMD_READ = 1'b1
   } command_type;

   typedef enum logic {
      KIND_FRAME = 1'b0,
      KIND_READ  = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      VERDICT_RECORDED  = 3'd0,
      VERDICT_BAD_IP    = 3'd1,
      VERDICT_BAD_TCP   = 3'd2,
      VERDICT_OTHER     = 3'd3,
      VERDICT_RANGE     = 3'd4,
      VERDICT_TRUNCATED = 3'd5
   } verdict_type;

   typedef enum logic [1:0] {
      STATUS_UNKNOWN = 2'd0,
      STATUS_OPEN    = 2'd1,
      STATUS_CLOSED  = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCAN_MODE  = 2'd0,
      CSR_PROBE_PORT = 2'd1,
      CSR_FIRST_PORT = 2'd2,
      CSR_PORT_COUNT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [7:0]        total;
      logic [3:0]        ip_words;
      logic [3:0]        tcp_words;
      logic [PORT_W-1:0] src_port;
      logic [PORT_W-1:0] dst_port;
      logic [7:0]        flags;
   } frame_info_type;

endpackage

// ===== design/tprc_req_if.sv =====
// request channel carrying frame bytes and table read commands
interface tprc_req_if
   import tprc_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic               command;
   logic [BYTE_W-1:0]  data_byte;
   logic               last_byte;
   logic [INDEX_W-1:0] read_index;

   modport source (output valid, output command, output data_byte, output last_byte,
                   output read_index, input ready);
   modport sink (input valid, input command, input data_byte, input last_byte,
                 input read_index, output ready);
endinterface

// ===== design/tprc_rsp_if.sv =====
// response channel carrying frame verdicts and table read replies
interface tprc_rsp_if
   import tprc_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic               reply_kind;
   logic [2:0]         verdict;
   logic [INDEX_W-1:0] port_index;
   logic [1:0]         port_status;
   logic [COUNT_W-1:0] responses_seen;
   logic               scan_done;

   modport source (output valid, output reply_kind, output verdict, output port_index,
                   output port_status, output responses_seen, output scan_done,
                   input ready);
   modport sink (input valid, input reply_kind, input verdict, input port_index,
                 input port_status, input responses_seen, input scan_done,
                 output ready);
endinterface

// ===== design/tcp_probe_reply_classifier_core.sv =====
// top level of the tcp probe reply classifier
//
// req channel: one transaction per captured frame byte (command 0, last_byte
// closes the frame) or per status table read (command 1, read_index).
// rsp channel: one transaction per closed frame (verdict, entry written and
// class) and one per table read (entry status); non-final bytes give none.
// csr port: csr_we writes csr_wdata into the register chosen by csr_index.
// a transaction can enter each cycle while req.ready is high; its response is
// registered first in the stage register, with the table read, and then in the output register.
// the status table is one memory of TABLE_PORTS two-bit entries with one
// write and one read port; a write and a read of the same entry in the
// same cycle are resolved by forwarding.
// after reset the table is swept to unknown, one entry per cycle, from entry
// zero to the last; req.ready stays low during that time.
// when the receiver stalls, the output register and one pipeline stage
// fill and req.ready drops until rsp.ready returns.
`include "tcp_probe_reply_classifier_core_assert.svh"
module tcp_probe_reply_classifier_core
   import tprc_pkg::*;
#(
   parameter int TABLE_PORTS = DEFAULT_TABLE_PORTS
) (
   input  logic                  clock,
   input  logic                  reset,
   tprc_req_if.sink              req,
   tprc_rsp_if.source            rsp,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW = $clog2(TABLE_PORTS);
   localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_PORTS - 1);
   localparam logic [16:0] TABLE_SIZE = 17'(TABLE_PORTS);

   // configuration
   logic                scan_mode_ff;
   logic [PORT_W-1:0]   probe_port_ff;
   logic [PORT_W-1:0]   first_port_ff;
   logic [PCOUNT_W-1:0] port_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_mode_ff  <= 1'b0;
         probe_port_ff <= '0;
         first_port_ff <= '0;
         port_count_ff <= PORT_COUNT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SCAN_MODE:  scan_mode_ff  <= csr_wdata[0];
            CSR_PROBE_PORT: probe_port_ff <= csr_wdata;
            CSR_FIRST_PORT: first_port_ff <= csr_wdata;
            CSR_PORT_COUNT: port_count_ff <= csr_wdata[PCOUNT_W-1:0];
            default:        scan_mode_ff  <= scan_mode_ff;
         endcase
      end
   end

   // handshake and pipeline control
   logic req_ready;
   logic req_acc;
   logic req_has_rsp;
   logic rd_acc;
   logic s1_adv;
   logic clearing_ff;
   logic clearing_in;
   logic [AW-1:0] clr_addr_ff;
   logic [AW-1:0] clr_addr_in;

   logic           s1_valid_ff;
   logic           s1_valid_in;
   kind_type       s1_kind_ff;
   frame_info_type s1_frame_ff;
   logic           s1_rd_ok_ff;
   logic [INDEX_W-1:0] s1_rd_index_ff;
   logic           s1_fwd_ff;
   status_type     s1_fwd_status_ff;

   logic rsp_valid_ff;
   logic rsp_valid_in;

   assign req_acc     = req.valid && req_ready;
   assign req_has_rsp = (req.command == CMD_READ) || req.last_byte;
   assign rd_acc      = req_acc && (req.command == CMD_READ);
   assign s1_adv      = s1_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req_ready   = !clearing_ff && (!s1_valid_ff || s1_adv);
   assign req.ready   = req_ready;

   // frame parsing
   frame_info_type frame_nxt;

   tprc_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .byte_vld  (req_acc && (req.command == CMD_BYTE)),
      .data_byte (req.data_byte),
      .last_byte (req.last_byte),
      .frame_nxt (frame_nxt)
   );

   // frame verdict in stage one
   verdict_type       s1_verdict;
   status_type        s1_class;
   logic [PORT_W-1:0] s1_diff;
   logic [7:0]        s1_need;
   logic              s1_wr;
   logic [AW-1:0]     wr_addr;
   logic [AW-1:0]     rd_addr;

   always_comb begin
      s1_diff  = s1_frame_ff.src_port - first_port_ff;
      s1_need  = ETH_LEN + {2'b00, s1_frame_ff.ip_words, 2'b00} + TCP_CAPTURE_LEN;
      s1_class = STATUS_UNKNOWN;
      if (s1_frame_ff.total <= ETH_LEN) begin
         s1_verdict = VERDICT_TRUNCATED;
      end else if (s1_frame_ff.ip_words < MIN_WORDS) begin
         s1_verdict = VERDICT_BAD_IP;
      end else if (s1_frame_ff.total < s1_need) begin
         s1_verdict = VERDICT_TRUNCATED;
      end else if (s1_frame_ff.tcp_words < MIN_WORDS) begin
         s1_verdict = VERDICT_BAD_TCP;
      end else if (s1_frame_ff.dst_port != probe_port_ff) begin
         s1_verdict = VERDICT_OTHER;
      end else if (s1_frame_ff.src_port < first_port_ff
                   || s1_diff >= {5'b00000, port_count_ff}
                   || {1'b0, s1_diff} >= TABLE_SIZE) begin
         s1_verdict = VERDICT_RANGE;
      end else begin
         s1_verdict = VERDICT_RECORDED;
         if (!scan_mode_ff && s1_frame_ff.flags == (FLAG_SYN | FLAG_ACK)) begin
            s1_class = STATUS_OPEN;
         end else if ((s1_frame_ff.flags & FLAG_RST) != 8'h00) begin
            s1_class = STATUS_CLOSED;
         end
      end
   end

   assign s1_wr   = s1_adv && (s1_kind_ff == KIND_FRAME) && (s1_verdict == VERDICT_RECORDED);
   assign wr_addr = AW'(s1_diff);
   assign rd_addr = AW'(req.read_index);

   // status table
   logic [1:0] table_mem [TABLE_PORTS];
   logic [1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         table_mem[clr_addr_ff] <= STATUS_UNKNOWN;
      end else if (s1_wr) begin
         table_mem[wr_addr] <= s1_class;
      end
      if (rd_acc) begin
         rd_data_ff <= table_mem[rd_addr];
      end
   end

   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         if (clr_addr_ff == LAST_ADDR) begin
            clearing_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // stage one register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_acc && req_has_rsp) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc && req_has_rsp) begin
         s1_kind_ff       <= (req.command == CMD_READ) ? KIND_READ : KIND_FRAME;
         s1_frame_ff      <= frame_nxt;
         s1_rd_ok_ff      <= 17'(req.read_index) < TABLE_SIZE;
         s1_rd_index_ff   <= req.read_index;
         s1_fwd_ff        <= rd_acc && s1_wr && (wr_addr == rd_addr);
         s1_fwd_status_ff <= s1_class;
      end
   end

   // response counter
   logic [COUNT_W-1:0] cnt_ff;
   logic [COUNT_W-1:0] cnt_in;

   assign cnt_in = (s1_wr && cnt_ff != COUNT_MAX) ? cnt_ff + 1'b1 : cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // output register
   kind_type           rsp_kind_ff;
   verdict_type        rsp_verdict_ff;
   logic [INDEX_W-1:0] rsp_index_ff;
   status_type         rsp_status_ff;
   logic [COUNT_W-1:0] rsp_seen_ff;
   logic               rsp_done_ff;
   status_type         rd_status;

   always_comb begin
      rd_status = STATUS_UNKNOWN;
      if (s1_rd_ok_ff) begin
         rd_status = s1_fwd_ff ? s1_fwd_status_ff : status_type'(rd_data_ff);
      end
   end

   assign rsp_valid_in = s1_adv ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_kind_ff <= s1_kind_ff;
         rsp_seen_ff <= cnt_in;
         rsp_done_ff <= cnt_in >= {5'b00000, port_count_ff};
         if (s1_kind_ff == KIND_READ) begin
            rsp_verdict_ff <= s1_rd_ok_ff ? VERDICT_RECORDED : VERDICT_RANGE;
            rsp_index_ff   <= s1_rd_index_ff;
            rsp_status_ff  <= rd_status;
         end else begin
            rsp_verdict_ff <= s1_verdict;
            rsp_index_ff   <= (s1_verdict == VERDICT_RECORDED) ? s1_diff[INDEX_W-1:0] : '0;
            rsp_status_ff  <= s1_class;
         end
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.reply_kind     = rsp_kind_ff;
   assign rsp.verdict        = rsp_verdict_ff;
   assign rsp.port_index     = rsp_index_ff;
   assign rsp.port_status    = rsp_status_ff;
   assign rsp.responses_seen = rsp_seen_ff;
   assign rsp.scan_done      = rsp_done_ff;

   // checks
   `TPRC_ASSERT_IMPLIES(a_no_accept_clearing, clock, reset, clearing_ff, !req_ready)
   `TPRC_ASSERT_NEXT(a_count_monotonic, clock, reset, 1'b1, cnt_ff >= $past(cnt_ff))
   `TPRC_ASSERT_NEXT(a_stage_holds, clock, reset, s1_valid_ff && !s1_adv, s1_valid_ff)
   `TPRC_ASSERT_IMPLIES(a_fwd_on_read, clock, reset, s1_valid_ff && s1_fwd_ff, s1_kind_ff == KIND_READ && s1_rd_ok_ff)

endmodule

// ===== design/tprc_parse.sv =====
// frame byte parser that captures ip and tcp header fields
module tprc_parse
   import tprc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              byte_vld,
   input  logic [BYTE_W-1:0] data_byte,
   input  logic              last_byte,
   output frame_info_type    frame_nxt
);

   localparam logic [7:0] OFF_SRC_HI = 8'd0;
   localparam logic [7:0] OFF_SRC_LO = 8'd1;
   localparam logic [7:0] OFF_DST_HI = 8'd2;
   localparam logic [7:0] OFF_DST_LO = 8'd3;
   localparam logic [7:0] OFF_DOFF   = 8'd12;
   localparam logic [7:0] OFF_FLAGS  = 8'd13;
   localparam logic [7:0] POS_MAX    = '1;

   logic [7:0]        byte_pos_ff;
   logic [3:0]        ip_words_ff;
   logic [3:0]        tcp_words_ff;
   logic [PORT_W-1:0] src_port_ff;
   logic [PORT_W-1:0] dst_port_ff;
   logic [7:0]        flags_ff;

   logic [7:0] tcp_start;
   logic [7:0] tcp_off;

   always_comb begin
      frame_nxt.total     = (byte_pos_ff == POS_MAX) ? POS_MAX : byte_pos_ff + 8'd1;
      frame_nxt.ip_words  = ip_words_ff;
      frame_nxt.tcp_words = tcp_words_ff;
      frame_nxt.src_port  = src_port_ff;
      frame_nxt.dst_port  = dst_port_ff;
      frame_nxt.flags     = flags_ff;
      tcp_start = ETH_LEN + {2'b00, ip_words_ff, 2'b00};
      tcp_off   = byte_pos_ff - tcp_start;
      if (byte_pos_ff == ETH_LEN) begin
         frame_nxt.ip_words = data_byte[3:0];
      end else if (byte_pos_ff > ETH_LEN && ip_words_ff >= MIN_WORDS) begin
         if (byte_pos_ff >= tcp_start && byte_pos_ff < tcp_start + TCP_CAPTURE_LEN) begin
            case (tcp_off)
               OFF_SRC_HI: frame_nxt.src_port[15:8] = data_byte;
               OFF_SRC_LO: frame_nxt.src_port[7:0]  = data_byte;
               OFF_DST_HI: frame_nxt.dst_port[15:8] = data_byte;
               OFF_DST_LO: frame_nxt.dst_port[7:0]  = data_byte;
               OFF_DOFF:   frame_nxt.tcp_words      = data_byte[7:4];
               OFF_FLAGS:  frame_nxt.flags          = data_byte;
               default:    frame_nxt.flags          = flags_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (byte_vld && last_byte)) begin
         byte_pos_ff  <= '0;
         ip_words_ff  <= '0;
         tcp_words_ff <= '0;
         src_port_ff  <= '0;
         dst_port_ff  <= '0;
         flags_ff     <= '0;
      end else if (byte_vld) begin
         byte_pos_ff  <= frame_nxt.total;
         ip_words_ff  <= frame_nxt.ip_words;
         tcp_words_ff <= frame_nxt.tcp_words;
         src_port_ff  <= frame_nxt.src_port;
         dst_port_ff  <= frame_nxt.dst_port;
         flags_ff     <= frame_nxt.flags;
      end
   end

endmodule

// ===== tb/sv/tcp_probe_reply_classifier_core_checker.sv =====
// reply predictor and scoreboard for the tcp probe reply classifier test
module tcp_probe_reply_classifier_core_checker
   import tprc_pkg::*;
#(
   parameter int TABLE_PORTS = DEFAULT_TABLE_PORTS
) (
   input  logic                  clock,
   input  logic                  reset,
   tprc_req_if                   req,
   tprc_rsp_if                   rsp,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatches,
   output int                    outstanding
);

   typedef struct {
      kind_type           kind;
      verdict_type        verdict;
      logic [INDEX_W-1:0] index;
      status_type         status;
      logic [COUNT_W-1:0] seen;
      logic               done;
   } reply_type;

   logic                cfg_fin;
   logic [PORT_W-1:0]   cfg_probe;
   logic [PORT_W-1:0]   cfg_first;
   logic [PCOUNT_W-1:0] cfg_count;

   int unsigned         byte_pos;
   int unsigned         ihl_words;
   int unsigned         doff_words;
   logic [PORT_W-1:0]   reply_src;
   logic [PORT_W-1:0]   reply_dst;
   logic [7:0]          tcp_flags;
   status_type          port_states [TABLE_PORTS];
   int unsigned         recorded_count;
   reply_type           pending_replies [$];

   function automatic reply_type make_reply(kind_type kind, verdict_type verdict,
                                            int unsigned index, status_type status);
      reply_type r;
      r.kind    = kind;
      r.verdict = verdict;
      r.index   = INDEX_W'(index);
      r.status  = status;
      r.seen    = COUNT_W'(recorded_count);
      r.done    = recorded_count >= cfg_count;
      return r;
   endfunction

   function automatic void clear_frame();
      byte_pos   = 0;
      ihl_words  = 0;
      doff_words = 0;
      reply_src  = '0;
      reply_dst  = '0;
      tcp_flags  = '0;
   endfunction

   function automatic void take_frame_byte(logic [7:0] b);
      int unsigned hdr_start;
      int unsigned offset;
      hdr_start = ETH_LEN + ihl_words * 4;
      if (byte_pos == ETH_LEN) begin
         ihl_words = b[3:0];
      end else if (byte_pos > ETH_LEN && ihl_words >= MIN_WORDS && byte_pos >= hdr_start &&
                   byte_pos < hdr_start + TCP_CAPTURE_LEN) begin
         offset = byte_pos - hdr_start;
         case (offset)
            0: reply_src[15:8] = b;
            1: reply_src[7:0] = b;
            2: reply_dst[15:8] = b;
            3: reply_dst[7:0] = b;
            12: doff_words = b[7:4];
            13: tcp_flags = b;
            default: ;
         endcase
      end
      if (byte_pos < 255) byte_pos++;
   endfunction

   function automatic reply_type close_frame();
      int unsigned offset;
      status_type  cls;
      reply_type   r;
      offset = reply_src - cfg_first;
      if (byte_pos <= ETH_LEN) begin
         r = make_reply(KIND_FRAME, VERDICT_TRUNCATED, 0, STATUS_UNKNOWN);
      end else if (ihl_words < MIN_WORDS) begin
         r = make_reply(KIND_FRAME, VERDICT_BAD_IP, 0, STATUS_UNKNOWN);
      end else if (byte_pos < ETH_LEN + ihl_words * 4 + TCP_CAPTURE_LEN) begin
         r = make_reply(KIND_FRAME, VERDICT_TRUNCATED, 0, STATUS_UNKNOWN);
      end else if (doff_words < MIN_WORDS) begin
         r = make_reply(KIND_FRAME, VERDICT_BAD_TCP, 0, STATUS_UNKNOWN);
      end else if (reply_dst != cfg_probe) begin
         r = make_reply(KIND_FRAME, VERDICT_OTHER, 0, STATUS_UNKNOWN);
      end else if (reply_src < cfg_first || offset >= cfg_count || offset >= TABLE_PORTS) begin
         r = make_reply(KIND_FRAME, VERDICT_RANGE, 0, STATUS_UNKNOWN);
      end else begin
         if (!cfg_fin && tcp_flags == (FLAG_SYN | FLAG_ACK)) cls = STATUS_OPEN;
         else if ((tcp_flags & FLAG_RST) != 0) cls = STATUS_CLOSED;
         else cls = STATUS_UNKNOWN;
         port_states[offset] = cls;
         if (recorded_count < COUNT_MAX) recorded_count++;
         r = make_reply(KIND_FRAME, VERDICT_RECORDED, offset, cls);
      end
      clear_frame();
      return r;
   endfunction

   function automatic reply_type lookup_entry(logic [INDEX_W-1:0] idx);
      if (idx < TABLE_PORTS) return make_reply(KIND_READ, VERDICT_RECORDED, idx, port_states[idx]);
      return make_reply(KIND_READ, VERDICT_RANGE, idx, STATUS_UNKNOWN);
   endfunction

   always @(posedge clock) begin : watch
      reply_type want;
      if (reset) begin
         cfg_fin   = 1'b0;
         cfg_probe = '0;
         cfg_first = '0;
         cfg_count = PORT_COUNT_RESET;
         clear_frame();
         foreach (port_states[i]) port_states[i] = STATUS_UNKNOWN;
         recorded_count = 0;
         pending_replies.delete();
         mismatches = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SCAN_MODE:  cfg_fin = csr_wdata[0];
               CSR_PROBE_PORT: cfg_probe = csr_wdata;
               CSR_FIRST_PORT: cfg_first = csr_wdata;
               CSR_PORT_COUNT: cfg_count = csr_wdata[PCOUNT_W-1:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready) begin
            if (req.command == CMD_READ) begin
               pending_replies.push_back(lookup_entry(req.read_index));
            end else begin
               take_frame_byte(req.data_byte);
               if (req.last_byte) pending_replies.push_back(close_frame());
            end
         end
         if (rsp.valid && rsp.ready) begin
            if (pending_replies.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected reply transaction: kind %0d verdict %0d index %0d status %0d",
                           rsp.reply_kind, rsp.verdict, rsp.port_index, rsp.port_status);
               mismatches++;
            end else begin
               want = pending_replies.pop_front();
               if (rsp.reply_kind !== want.kind || rsp.verdict !== want.verdict ||
                   rsp.port_index !== want.index || rsp.port_status !== want.status ||
                   rsp.responses_seen !== want.seen || rsp.scan_done !== want.done) begin
                  if (mismatches < 10) begin
                     $display("reply mismatch: expected kind %0d verdict %0d index %0d status %0d",
                              want.kind, want.verdict, want.index, want.status);
                     $display("   expected seen %0d done %0d", want.seen, want.done);
                     $display("   got kind %0d verdict %0d index %0d status %0d seen %0d done %0d",
                              rsp.reply_kind, rsp.verdict, rsp.port_index, rsp.port_status,
                              rsp.responses_seen, rsp.scan_done);
                  end
                  mismatches++;
               end
            end
         end
      end
      outstanding <= pending_replies.size();
   end

endmodule

// ===== tb/sv/tcp_probe_reply_classifier_core_test.sv =====
// stimulus and verdict for the tcp probe reply classifier test
module tcp_probe_reply_classifier_core_test;
   import tprc_pkg::*;

   localparam int TABLE_PORTS    = DEFAULT_TABLE_PORTS;
   localparam int WATCHDOG_LIMIT = 6000;
   localparam int LINGER         = 8;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    mismatches;
   int                    outstanding;

   bit                    calm;
   int unsigned           items_sent;
   int unsigned           frames_sent;
   logic [PORT_W-1:0]     cur_probe;
   logic [PORT_W-1:0]     cur_first;
   logic [PCOUNT_W-1:0]   cur_count;
   logic [7:0]            frame_bytes [$];

   tprc_req_if req_bus ();
   tprc_rsp_if rsp_bus ();

   tcp_probe_reply_classifier_core #(.TABLE_PORTS(TABLE_PORTS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .rsp       (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   tcp_probe_reply_classifier_core_checker #(.TABLE_PORTS(TABLE_PORTS)) scoreboard (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= calm || ($urandom_range(99) >= 29);
      end
   end

   initial begin : watchdog
      int stalled;
      stalled = 0;
      while (stalled < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) stalled = 0;
         else stalled++;
      end
      $display("tcp_probe_reply_classifier_core_test: errors");
      $finish;
   end

   task automatic send_item(input command_type cmd, input logic [7:0] data, input logic last,
                            input logic [INDEX_W-1:0] idx);
      while (!calm && $urandom_range(99) < 29) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.command    <= cmd;
      req_bus.data_byte  <= data;
      req_bus.last_byte  <= last;
      req_bus.read_index <= idx;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      items_sent++;
   endtask

   function automatic logic [INDEX_W-1:0] pick_index();
      return $urandom_range(1) ? INDEX_W'($urandom_range(15)) : INDEX_W'($urandom);
   endfunction

   task automatic read_entry(input logic [INDEX_W-1:0] idx);
      send_item(CMD_READ, 8'($urandom), 1'($urandom), idx);
   endtask

   function automatic void compose_frame(input logic [3:0] ihl, input logic [3:0] doff,
                                         input logic [15:0] src, input logic [15:0] dst,
                                         input logic [7:0] flags, input int unsigned extra);
      int unsigned ip_len;
      ip_len = (ihl >= MIN_WORDS) ? ihl * 4 : 20;
      frame_bytes.delete();
      repeat (ETH_LEN) frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back({4'($urandom), ihl});
      repeat (ip_len - 1) frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back(src[15:8]);
      frame_bytes.push_back(src[7:0]);
      frame_bytes.push_back(dst[15:8]);
      frame_bytes.push_back(dst[7:0]);
      repeat (8) frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back({doff, 4'($urandom)});
      frame_bytes.push_back(flags);
      repeat (extra) frame_bytes.push_back(8'($urandom));
   endfunction

   task automatic push_frame(input logic [3:0] ihl, input logic [3:0] doff,
                             input logic [15:0] src, input logic [15:0] dst,
                             input logic [7:0] flags, input int unsigned extra,
                             input int unsigned cut, input bit with_reads);
      int unsigned n;
      compose_frame(ihl, doff, src, dst, flags, extra);
      n = (cut != 0 && cut < frame_bytes.size()) ? cut : frame_bytes.size();
      for (int unsigned i = 0; i < n; i++) begin
         if (with_reads && $urandom_range(99) < 8) read_entry(pick_index());
         send_item(CMD_BYTE, frame_bytes[i], i == n - 1, INDEX_W'($urandom));
      end
      frames_sent++;
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic configure(input logic fin, input logic [15:0] probe, input logic [15:0] first,
                            input logic [PCOUNT_W-1:0] count);
      write_csr(CSR_SCAN_MODE, CSR_DATA_W'(fin));
      write_csr(CSR_PROBE_PORT, probe);
      write_csr(CSR_FIRST_PORT, first);
      write_csr(CSR_PORT_COUNT, CSR_DATA_W'(count));
      csr_we    <= 1'b0;
      cur_probe = probe;
      cur_first = first;
      cur_count = count;
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (LINGER) @(posedge clock);
   endtask

   task automatic random_config();
      logic [15:0]         probe;
      logic [15:0]         first;
      logic [PCOUNT_W-1:0] count;
      case ($urandom_range(3))
         0: probe = 16'h0000;
         1: probe = 16'hffff;
         default: probe = 16'($urandom);
      endcase
      case ($urandom_range(3))
         0: first = 16'h0000;
         1: first = 16'hffff - 16'($urandom_range(1023));
         default: first = 16'($urandom);
      endcase
      case ($urandom_range(7))
         0: count = 11'd1;
         1: count = 11'd1024;
         2: count = 11'd0;
         3: count = 11'd2047;
         default: count = PCOUNT_W'($urandom_range(1, 1024));
      endcase
      configure(1'($urandom), probe, first, count);
   endtask

   task automatic random_frame();
      logic [3:0]  ihl;
      logic [3:0]  doff;
      logic [15:0] src;
      logic [15:0] dst;
      logic [7:0]  flags;
      int unsigned roll;
      int unsigned span;
      int unsigned extra;
      int unsigned cut;
      roll = $urandom_range(99);
      if (roll < 6) ihl = 4'($urandom_range(4));
      else if (roll < 10) ihl = 4'd15;
      else ihl = 4'($urandom_range(5, 7));
      doff = ($urandom_range(99) < 7) ? 4'($urandom_range(4)) : 4'($urandom_range(5, 15));
      dst = ($urandom_range(99) < 85) ? cur_probe : 16'($urandom);
      span = (cur_count > 11'd1024) ? 1026 : cur_count + 1;
      roll = $urandom_range(99);
      if (roll < 45) src = cur_first + 16'($urandom_range(15));
      else if (roll < 80) src = cur_first + 16'($urandom_range(span));
      else if (roll < 90) src = cur_first - 16'($urandom_range(1, 3));
      else src = 16'($urandom);
      case ($urandom_range(7))
         0, 1: flags = FLAG_SYN | FLAG_ACK;
         2: flags = FLAG_RST | FLAG_ACK;
         3: flags = FLAG_RST;
         4: flags = FLAG_SYN;
         5: flags = FLAG_ACK;
         default: flags = 8'($urandom);
      endcase
      extra = ($urandom_range(99) < 4) ? $urandom_range(150, 230) : $urandom_range(2);
      cut = ($urandom_range(99) < 12) ? $urandom_range(1, 60) : 0;
      push_frame(ihl, doff, src, dst, flags, extra, cut, 1'b1);
   endtask

   initial begin : stimulus
      int unsigned phase_start;
      calm        = 1'b0;
      items_sent  = 0;
      frames_sent = 0;
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.command    <= CMD_BYTE;
      req_bus.data_byte  <= '0;
      req_bus.last_byte  <= 1'b0;
      req_bus.read_index <= '0;
      csr_we             <= 1'b0;
      csr_index          <= CSR_SCAN_MODE;
      csr_wdata          <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // syn mode, probe port at the top of the range
      configure(1'b0, 16'hffff, 16'h0000, 11'd1024);
      push_frame(5, 5, 16'd0, 16'hffff, FLAG_SYN | FLAG_ACK, 0, 14, 1'b0);
      push_frame(5, 5, 16'd0, 16'hffff, FLAG_SYN | FLAG_ACK, 0, 15, 1'b0);
      push_frame(4, 5, 16'd0, 16'hffff, FLAG_SYN | FLAG_ACK, 0, 0, 1'b0);
      push_frame(5, 4, 16'd0, 16'hffff, FLAG_SYN | FLAG_ACK, 0, 0, 1'b0);
      push_frame(5, 5, 16'd0, 16'hfffe, FLAG_SYN | FLAG_ACK, 0, 0, 1'b0);
      push_frame(5, 5, 16'd0, 16'hffff, FLAG_SYN | FLAG_ACK, 5, 48, 1'b0);
      push_frame(5, 15, 16'd1023, 16'hffff, FLAG_SYN | FLAG_ACK, 0, 0, 1'b1);
      push_frame(5, 5, 16'd1024, 16'hffff, FLAG_SYN | FLAG_ACK, 0, 0, 1'b0);
      push_frame(15, 15, 16'd5, 16'hffff, FLAG_RST, 170, 0, 1'b0);
      read_entry(10'd0);
      read_entry(10'd5);
      read_entry(10'd1023);
      settle();

      // fin mode, first port at the top of the range, a single port
      configure(1'b1, 16'h0000, 16'hffff, 11'd1);
      push_frame(5, 5, 16'hffff, 16'h0000, FLAG_RST, 0, 0, 1'b0);
      read_entry(10'd0);
      settle();

      for (int phase = 0; phase < 2 || items_sent < 750; phase++) begin
         random_config();
         calm = (phase == 1);
         phase_start = frames_sent;
         while (frames_sent - phase_start < 2) begin
            if ($urandom_range(15) == 0) repeat ($urandom_range(1, 4)) read_entry(pick_index());
            random_frame();
         end
         calm = 1'b0;
         settle();
      end

      if (mismatches == 0 && outstanding == 0)
         $display("tcp_probe_reply_classifier_core_test: clean");
      else
         $display("tcp_probe_reply_classifier_core_test: errors");
      $finish;
   end

endmodule
